// ----- sv/lsw_pkg.sv -----
// Shared constants for the line stamp walker.
package lsw_pkg;

  // Brush word width and configuration register width
  localparam int BRUSH_BITS = 32;
  localparam int CFG_BITS   = 4;

  // Stamp repeat index width and repeat limits
  localparam int                IDX_BITS     = 3;
  localparam logic [CFG_BITS-1:0] STAMPS_RESET = 4'd5;
  localparam logic [CFG_BITS-1:0] MAX_STAMPS   = 4'd8;

  // Item kinds carried on in_tuser
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  // Stamp count minus one, for one point
  typedef logic [IDX_BITS-1:0] stamp_idx_t;

endpackage

// ----- sv/line_stamp_walker.sv -----
// Bresenham line walker that emits a run of stamp requests for each line point.
//
// A start item (in_tuser = 0) loads the endpoints and brush words and
// gives no result. An advance item (in_tuser = 1) on a loaded line gives N stamp
// transfers for the current point, N being stamps_per_point held to 1..8, and
// steps the line in the cycle it is accepted; an advance with no loaded line is
// taken and gives nothing. Results leave at one per cycle from the output
// register while out_tready is high; a one-entry holding stage in front of the
// output register lets the next item be taken while the current run is still
// draining. out_tlast marks the final stamp of a point and out_tuser the line's
// final point.
module line_stamp_walker #(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst_n,
  // Configuration: stamps_per_point
  input  logic                         cfg_wr_en,
  input  logic [lsw_pkg::CFG_BITS-1:0] cfg_wr_data,
  // Input channel
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // tdata, low bit up: x_start, y_start, x_end, y_end, brush_value_in,
  // brush_blend_in, zero fill to whole bytes
  input  logic [((4*COORD_BITS+2*lsw_pkg::BRUSH_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: kind
  input  logic                                           in_tuser,
  // Result channel
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // tdata, low bit up: x_point, y_point, delta_x, target_y, brush_value_out,
  // brush_blend_out, stamp_index, zero fill to whole bytes
  output logic [((4*COORD_BITS+2*lsw_pkg::BRUSH_BITS+lsw_pkg::IDX_BITS+7)/8)*8-1:0]
                                                         out_tdata,
  // tlast: last_stamp
  output logic                                           out_tlast,
  // tuser: last_point
  output logic                                           out_tuser
);
  import lsw_pkg::*;

  localparam int CB       = COORD_BITS;
  localparam int OUT_USED = 4*CB + 2*BRUSH_BITS + IDX_BITS;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_USED;

  // Configuration register
  logic [CFG_BITS-1:0] spp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= STAMPS_RESET;
    end else if (cfg_wr_en) begin
      spp_r <= cfg_wr_data;
    end
  end

  // Stamp count minus one, zero read as one and large values held at eight
  stamp_idx_t nm1;
  always_comb begin
    if (spp_r == '0) begin
      nm1 = '0;
    end else if (spp_r > MAX_STAMPS) begin
      nm1 = IDX_BITS'(MAX_STAMPS - 1'b1);
    end else begin
      nm1 = IDX_BITS'(spp_r - 1'b1);
    end
  end

  // Line state
  logic signed [CB-1:0]   x_pos_r, y_pos_r, end_y_r;
  logic                   x_neg_r, y_neg_r, x_major_r;
  logic [CB-1:0]          adx_r, ady_r;
  logic signed [CB+1:0]   err_r;
  logic [CB:0]            left_r;
  logic [BRUSH_BITS-1:0]  value_r, blend_r;
  logic                   active_r;

  // Holding stage and output register
  logic                   pend_valid_r;
  logic signed [CB-1:0]   pend_x_r, pend_y_r, pend_ty_r;
  logic [CB-1:0]          pend_dx_r;
  logic [BRUSH_BITS-1:0]  pend_val_r, pend_bl_r;
  stamp_idx_t             pend_nm1_r;
  logic                   pend_lastpt_r;

  logic                   out_valid_r;
  logic signed [CB-1:0]   out_x_r, out_y_r, out_ty_r;
  logic [CB-1:0]          out_dx_r;
  logic [BRUSH_BITS-1:0]  out_val_r, out_bl_r;
  stamp_idx_t             out_idx_r, out_nm1_r;
  logic                   out_lastpt_r;

  // Handshake decode
  logic in_take, start_fire, adv_fire, out_xfer, out_done, out_load;

  assign out_xfer   = out_valid_r && out_tready;
  assign out_done   = out_xfer && (out_idx_r == out_nm1_r);
  assign out_load   = pend_valid_r && (!out_valid_r || out_done);
  assign in_tready  = !pend_valid_r || out_load;
  assign in_take    = in_tvalid && in_tready;
  assign start_fire = in_take && (in_tuser == KIND_START);
  assign adv_fire   = in_take && (in_tuser == KIND_ADVANCE) && active_r;

  // Start item: deltas, signs, major axis, initial error
  logic signed [CB-1:0] x0, y0, x1, y1;
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          dx_abs_w, dy_abs_w;
  logic [CB-1:0]        adx_nxt, ady_nxt, major_nxt;
  logic                 x_major_nxt;

  always_comb begin
    x0 = in_tdata[CB-1:0];
    y0 = in_tdata[2*CB-1:CB];
    x1 = in_tdata[3*CB-1:2*CB];
    y1 = in_tdata[4*CB-1:3*CB];
    dx = {x1[CB-1], x1} - {x0[CB-1], x0};
    dy = {y1[CB-1], y1} - {y0[CB-1], y0};
    dx_abs_w    = dx[CB] ? -dx : dx;
    dy_abs_w    = dy[CB] ? -dy : dy;
    adx_nxt     = dx_abs_w[CB-1:0];
    ady_nxt     = dy_abs_w[CB-1:0];
    x_major_nxt = adx_nxt > ady_nxt;
    major_nxt   = x_major_nxt ? adx_nxt : ady_nxt;
  end

  // Advance: one major step, minor step when the error turns non-negative
  logic signed [CB-1:0] x_step, y_step, x_adv, y_adv;
  logic signed [CB+2:0] err_add, err_sub;
  logic [CB-1:0]        minor, major;
  logic signed [CB+1:0] err_adv;

  always_comb begin
    x_step  = x_pos_r + (x_neg_r ? {CB{1'b1}} : CB'(1));
    y_step  = y_pos_r + (y_neg_r ? {CB{1'b1}} : CB'(1));
    minor   = x_major_r ? ady_r : adx_r;
    major   = x_major_r ? adx_r : ady_r;
    err_add = {err_r[CB+1], err_r} + (CB+3)'({minor, 1'b0});
    err_sub = err_add - (CB+3)'({major, 1'b0});
    x_adv   = x_pos_r;
    y_adv   = y_pos_r;
    if (err_add[CB+2]) begin
      err_adv = err_add[CB+1:0];
      if (x_major_r) x_adv = x_step;
      else           y_adv = y_step;
    end else begin
      err_adv = err_sub[CB+1:0];
      x_adv   = x_step;
      y_adv   = y_step;
    end
  end

  // Line state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_pos_r   <= '0;
      y_pos_r   <= '0;
      end_y_r   <= '0;
      x_neg_r   <= 1'b0;
      y_neg_r   <= 1'b0;
      x_major_r <= 1'b0;
      adx_r     <= '0;
      ady_r     <= '0;
      err_r     <= '0;
      left_r    <= '0;
      value_r   <= '0;
      blend_r   <= '0;
      active_r  <= 1'b0;
    end else if (start_fire) begin
      x_pos_r   <= x0;
      y_pos_r   <= y0;
      end_y_r   <= y1;
      x_neg_r   <= dx[CB];
      y_neg_r   <= dy[CB];
      x_major_r <= x_major_nxt;
      adx_r     <= adx_nxt;
      ady_r     <= ady_nxt;
      err_r     <= -(CB+2)'(major_nxt);
      left_r    <= (CB+1)'(major_nxt) + 1'b1;
      value_r   <= in_tdata[4*CB+BRUSH_BITS-1:4*CB];
      blend_r   <= in_tdata[4*CB+2*BRUSH_BITS-1:4*CB+BRUSH_BITS];
      active_r  <= 1'b1;
    end else if (adv_fire) begin
      x_pos_r   <= x_adv;
      y_pos_r   <= y_adv;
      err_r     <= err_adv;
      left_r    <= left_r - 1'b1;
      active_r  <= (left_r != (CB+1)'(1));
    end
  end

  // Holding stage and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_idx_r    <= '0;
    end else begin
      if (adv_fire) begin
        pend_valid_r <= 1'b1;
      end else if (out_load) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_idx_r   <= '0;
      end else if (out_done) begin
        out_valid_r <= 1'b0;
      end else if (out_xfer) begin
        out_idx_r <= out_idx_r + 1'b1;
      end
    end
  end

  // Payload of the held point and of the output register
  always_ff @(posedge clk) begin
    if (adv_fire) begin
      pend_x_r      <= x_pos_r;
      pend_y_r      <= y_pos_r;
      pend_dx_r     <= adx_r;
      pend_ty_r     <= end_y_r;
      pend_val_r    <= value_r;
      pend_bl_r     <= blend_r;
      pend_nm1_r    <= nm1;
      pend_lastpt_r <= (left_r == (CB+1)'(1));
    end
    if (out_load) begin
      out_x_r      <= pend_x_r;
      out_y_r      <= pend_y_r;
      out_dx_r     <= pend_dx_r;
      out_ty_r     <= pend_ty_r;
      out_val_r    <= pend_val_r;
      out_bl_r     <= pend_bl_r;
      out_nm1_r    <= pend_nm1_r;
      out_lastpt_r <= pend_lastpt_r;
    end
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_idx_r, out_bl_r, out_val_r, out_ty_r, out_dx_r,
                       out_y_r, out_x_r};
  assign out_tlast  = (out_idx_r == out_nm1_r);
  assign out_tuser  = out_lastpt_r;

  // A loaded line always has at least one point left
  a_active_left: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (left_r != '0))
    else $error("active line with no points left");

  // The repeat index never runs past the stamp count of its point
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idx_r <= out_nm1_r))
    else $error("stamp index beyond stamp count");

  // A non-final stamp transfer is followed by the next repeat of the same point
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_tlast) |=>
      (out_valid_r && (out_idx_r == IDX_BITS'($past(out_idx_r) + 1'b1))))
    else $error("stamp run broken");

  // The holding stage is never overwritten while full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && !out_load) |-> !in_tready)
    else $error("holding stage overrun");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for line_stamp_walker: line stimulus, stamp prediction and scoring.
`timescale 1ns / 100ps

module tb;
  import lsw_pkg::*;

  localparam int COORD       = 12;
  localparam int IN_W        = ((4*COORD+2*BRUSH_BITS+7)/8)*8;
  localparam int OUT_W       = ((4*COORD+2*BRUSH_BITS+IDX_BITS+7)/8)*8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_CYCLES = 300;

  // One expected stamp request
  typedef struct packed {
    logic [COORD-1:0]      x_point;
    logic [COORD-1:0]      y_point;
    logic [COORD-1:0]      delta_x;
    logic [COORD-1:0]      target_y;
    logic [BRUSH_BITS-1:0] value_word;
    logic [BRUSH_BITS-1:0] blend_word;
    stamp_idx_t            stamp_index;
    logic                  last_stamp;
    logic                  last_point;
  } stamp_req_t;

  // Line walker predictor plus queue of pending stamp requests
  class stamp_scoreboard;
    stamp_req_t       pending_stamps[$];
    logic [3:0]       stamps_cfg;
    logic [COORD-1:0] x_pos, y_pos, end_y, abs_dx, abs_dy;
    logic [31:0]      value_word, blend_word;
    logic             x_neg, y_neg, x_major, line_on;
    int               err_acc;
    int               points_left;
    int               errors;

    function new();
      errors      = 0;
      stamps_cfg  = STAMPS_RESET;
      x_pos       = '0;
      y_pos       = '0;
      end_y       = '0;
      abs_dx      = '0;
      abs_dy      = '0;
      value_word  = '0;
      blend_word  = '0;
      x_neg       = 1'b0;
      y_neg       = 1'b0;
      x_major     = 1'b0;
      line_on     = 1'b0;
      err_acc     = 0;
      points_left = 0;
    endfunction

    function void set_stamps(logic [3:0] v);
      stamps_cfg = v;
    endfunction

    function int pending();
      return pending_stamps.size();
    endfunction

    // Accepted input transfer: load a line or emit the current point
    function void note_input(logic kind, logic [IN_W-1:0] d);
      int         x0, y0, x1, y1, dx, dy, n;
      stamp_req_t s;
      if (kind == KIND_START) begin
        x0 = $signed(d[11:0]);
        y0 = $signed(d[23:12]);
        x1 = $signed(d[35:24]);
        y1 = $signed(d[47:36]);
        dx = x1 - x0;
        dy = y1 - y0;
        x_neg = dx < 0;
        y_neg = dy < 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        abs_dx  = dx[COORD-1:0];
        abs_dy  = dy[COORD-1:0];
        x_major = dx > dy;
        err_acc     = x_major ? -dx : -dy;
        points_left = (x_major ? dx : dy) + 1;
        x_pos      = d[11:0];
        y_pos      = d[23:12];
        end_y      = d[47:36];
        value_word = d[79:48];
        blend_word = d[111:80];
        line_on    = 1'b1;
        return;
      end
      if (!line_on) return;

      // Repeat count held to 1..8
      if (stamps_cfg == 0) n = 1;
      else if (stamps_cfg > MAX_STAMPS) n = MAX_STAMPS;
      else n = stamps_cfg;

      for (int k = 0; k < n; k++) begin
        s.x_point     = x_pos;
        s.y_point     = y_pos;
        s.delta_x     = abs_dx;
        s.target_y    = end_y;
        s.value_word  = value_word;
        s.blend_word  = blend_word;
        s.stamp_index = k[IDX_BITS-1:0];
        s.last_stamp  = (k == n - 1);
        s.last_point  = (points_left == 1);
        pending_stamps.push_back(s);
      end

      // Step along the major axis, minor axis when the error turns non-negative
      if (x_major) begin
        x_pos = x_neg ? x_pos - 1'b1 : x_pos + 1'b1;
        err_acc += 2 * int'(abs_dy);
        if (err_acc >= 0) begin
          err_acc -= 2 * int'(abs_dx);
          y_pos = y_neg ? y_pos - 1'b1 : y_pos + 1'b1;
        end
      end else begin
        y_pos = y_neg ? y_pos - 1'b1 : y_pos + 1'b1;
        err_acc += 2 * int'(abs_dx);
        if (err_acc >= 0) begin
          err_acc -= 2 * int'(abs_dy);
          x_pos = x_neg ? x_pos - 1'b1 : x_pos + 1'b1;
        end
      end
      if (points_left > 0) points_left--;
      if (points_left == 0) line_on = 1'b0;
    endfunction

    function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Accepted result transfer: score against the oldest pending request
    function void check_result(logic [OUT_W-1:0] d, logic tl, logic tu);
      stamp_req_t e;
      if (pending_stamps.size() == 0) begin
        $display("%0t: stamp request with none pending: expected nothing, actual %h",
                 $time, d);
        errors++;
        return;
      end
      e = pending_stamps.pop_front();
      compare("x_point",         e.x_point,     d[11:0]);
      compare("y_point",         e.y_point,     d[23:12]);
      compare("delta_x",         e.delta_x,     d[35:24]);
      compare("target_y",        e.target_y,    d[47:36]);
      compare("brush_value_out", e.value_word,  d[79:48]);
      compare("brush_blend_out", e.blend_word,  d[111:80]);
      compare("stamp_index",     e.stamp_index, d[114:112]);
      compare("last_stamp",      e.last_stamp,  tl);
      compare("last_point",      e.last_point,  tu);
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [3:0]       cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata    = '0;
  logic             in_tuser    = 1'b0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tlast;
  logic             out_tuser;

  stamp_scoreboard sb;
  logic calm        = 1'b0;
  logic hold_done   = 1'b0;
  int   hold_left   = 0;
  int   stamps_seen = 0;
  int   cycle_count = 0;

  line_stamp_walker #(.COORD_BITS(COORD)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: score transfers, random backpressure, one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tlast, out_tuser);
      stamps_seen++;
    end
    if (!hold_done && stamps_seen >= 150) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  function automatic int mag(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic logic [IN_W-1:0] pack_line(int x0, int y0, int x1, int y1,
                                                logic [31:0] v, logic [31:0] b);
    return {b, v, y1[11:0], x1[11:0], y0[11:0], x0[11:0]};
  endfunction

  // Advance payload is ignored, so fill it with junk
  function automatic logic [IN_W-1:0] noise();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[IN_W-1:0];
  endfunction

  // Offer one item, with an occasional gap first, and wait for the transfer
  task automatic push_item(input logic kind, input logic [IN_W-1:0] d);
    if (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(kind, d);
  endtask

  task automatic run_line(input int x0, input int y0, input int x1, input int y1,
                          input int advances, input logic [31:0] v, input logic [31:0] b);
    push_item(KIND_START, pack_line(x0, y0, x1, y1, v, b));
    repeat (advances) push_item(KIND_ADVANCE, noise());
  endtask

  // Stop offering, wait for every pending stamp, then let the pipe settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_stamps(input logic [3:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_stamps(v);
  endtask

  // Mostly complete short lines; some abandoned, some with extra advances,
  // a few long lines with random endpoints cut short
  task automatic random_phase(input int budget);
    int x0, y0, x1, y1, pts, adv, r, used;
    used = 0;
    while (used < budget) begin
      x0 = int'($urandom_range(0, 4095)) - 2048;
      y0 = int'($urandom_range(0, 4095)) - 2048;
      if ($urandom_range(0, 99) < 12) begin
        x1 = int'($urandom_range(0, 4095)) - 2048;
        y1 = int'($urandom_range(0, 4095)) - 2048;
      end else begin
        x1 = clamp_coord(x0 + int'($urandom_range(0, 14)) - 7);
        y1 = clamp_coord(y0 + int'($urandom_range(0, 14)) - 7);
      end
      pts = (mag(x1 - x0) > mag(y1 - y0) ? mag(x1 - x0) : mag(y1 - y0)) + 1;
      r = $urandom_range(0, 99);
      if (pts > 16) adv = $urandom_range(0, 10);
      else if (r < 70) adv = pts;
      else if (r < 85) adv = $urandom_range(0, pts - 1);
      else adv = pts + int'($urandom_range(1, 3));
      run_line(x0, y0, x1, y1, adv, $urandom, $urandom);
      used += 1 + (adv < pts ? adv : pts);
    end
  endtask

  initial begin
    logic [3:0] phase_cfg [7];
    sb = new();
    phase_cfg = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd9, 4'd3, 4'd0};
    phase_cfg[6] = $urandom_range(0, 15);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: advance with no line loaded
    push_item(KIND_ADVANCE, noise());
    // Zero-length line at the corner, then an advance past its end
    run_line(-2048, 2047, -2048, 2047, 2, 32'h0000_0000, 32'hFFFF_FFFF);
    // Equal deltas: y is the major axis
    run_line(0, 0, 3, -3, 4, 32'hFFFF_FFFF, 32'h0000_0000);
    // Shallow line stepping toward negative x from the top edge
    run_line(2047, -2048, 2043, -2046, 5, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    // Full diagonal, abandoned by a new steep line
    run_line(-2048, -2048, 2047, 2047, 3, $urandom, $urandom);
    run_line(5, 5, 4, 7, 3, $urandom, $urandom);

    // Random phases across the repeat-count settings
    for (int p = 0; p < 7; p++) begin
      write_stamps(phase_cfg[p]);
      calm = (p == 3);
      random_phase(48);
    end
    calm = 1'b0;

    drain();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/lsw_pkg.sv
sv/line_stamp_walker.sv
tb/tb.sv
